/* src/spd_pkg.sv */
// Shared codes and fixed field widths for the shortest-path unit.
// No dependencies; every other file imports this package.
`default_nettype none
package spd_pkg;

  localparam int unsigned NODE_W = 6;
  localparam int unsigned DIST_W = 32;
  localparam int unsigned PRED_W = 7;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned WIN_W  = 16;

  // Node table size; the node and predecessor field widths above are sized for it.
  localparam int unsigned MAX_NODES = 64;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_RUN   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_FULL = 2'd1,
    ERR_NODE = 2'd2,
    ERR_RSVD = 2'd3
  } err_t;

endpackage
`default_nettype wire

/* src/spd_if.sv */
// Valid/ready channel interfaces for command words and result words.
// Depends on spd_pkg for field widths.
`default_nettype none
interface spd_in_if;
  import spd_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [NODE_W-1:0] from_node;
  logic [NODE_W-1:0] to_node;
  logic [WIN_W-1:0]  edge_weight;
  logic [NODE_W-1:0] start_node;
  modport source (output valid, op, from_node, to_node, edge_weight, start_node,
                  input ready);
  modport sink   (input valid, op, from_node, to_node, edge_weight, start_node,
                  output ready);
endinterface

interface spd_out_if;
  import spd_pkg::*;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] node;
  logic [DIST_W-1:0] distance;
  logic [PRED_W-1:0] predecessor;
  logic [1:0]        error;
  logic              last;
  modport source (output valid, node, distance, predecessor, error, last,
                  input ready);
  modport sink   (input valid, node, distance, predecessor, error, last,
                  output ready);
endinterface
`default_nettype wire

/* src/shortest_path_dijkstra_unit.sv */
// Shortest-path unit: edge store load, then Dijkstra runs over node memory.
// Depends on spd_pkg and the channel interfaces in spd_if.sv.
// Clear and add-edge words may follow back to back while no result word is stalled.
// A run round scans every node, emits the previous node's result word (held while the
// output stalls), then checks every stored edge against the newly finalized node.
// Reset (rst_n low, synchronous) empties the edge store and sets node_count to 64.
`default_nettype none
module shortest_path_dijkstra_unit #(
  parameter int unsigned MAX_EDGES   = 1024,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [spd_pkg::CNT_W-1:0] cfg_data,
  spd_in_if.sink                    in_ch,
  spd_out_if.source                 out_ch
);
  import spd_pkg::*;

  // Widths that follow from the parameters.
  localparam int unsigned NIW  = $clog2(MAX_NODES);
  localparam int unsigned CW0  = $clog2(MAX_NODES + 1);
  localparam int unsigned CW   = (CW0 > CNT_W) ? CW0 : CNT_W;
  localparam int unsigned PW   = CW0;
  localparam int unsigned EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ETW  = $clog2(MAX_EDGES + 1);
  localparam logic [PW-1:0] PRED_NONE = PW'(MAX_NODES);
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // An edge entry holds tail, head and the masked weight.
  typedef struct packed {
    logic [NODE_W-1:0]      from_n;
    logic [NODE_W-1:0]      to_n;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_ent_t;

  // A node entry holds the best known distance and its predecessor.
  typedef struct packed {
    logic [DIST_W-1:0] dval;
    logic [PW-1:0]     pred;
  } node_ent_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EDGE_RD,
    S_EDGE_CHK,
    S_NODE_WR,
    S_EMIT
  } state_t;

  // Memories: the edge store and the per-node distance table. Both have one
  // write port and one registered read port. Node entries that were never
  // written are only read for nodes not yet reached, where the value is unused.
  edge_ent_t edge_mem [MAX_EDGES];
  node_ent_t node_mem [MAX_NODES];

  state_t            state_r;
  logic [CNT_W-1:0]  node_count_r;
  logic [ETW-1:0]    edge_total_r;
  logic [ETW-1:0]    e_r;
  logic [MAX_NODES-1:0] reached_r;
  logic [MAX_NODES-1:0] visited_r;
  logic [CW-1:0]     scan_i_r;
  logic              scan_vld_r;
  logic [NIW-1:0]    scan_idx_r;
  logic              found_r;
  logic [NIW-1:0]    best_u_r;
  node_ent_t         best_r;
  logic              have_pend_r;
  logic [NIW-1:0]    u_r;
  node_ent_t         pend_r;
  logic [NIW-1:0]    tgt_r;
  edge_ent_t         edge_q;
  node_ent_t         node_q;

  logic              out_valid_r;
  logic [NODE_W-1:0] out_node_r;
  logic [DIST_W-1:0] out_dist_r;
  logic [PRED_W-1:0] out_pred_r;
  err_t              out_err_r;
  logic              out_last_r;

  // Combinational helpers.
  logic [CW-1:0]     n_eff;
  logic              in_fire;
  logic              out_fire;
  logic              from_bad;
  logic              to_bad;
  logic              start_bad;
  logic              edge_we;
  edge_ent_t         edge_wd;
  logic              node_we;
  logic [NIW-1:0]    node_wa;
  node_ent_t         node_wd;
  logic [NIW-1:0]    node_ra;
  logic [DIST_W:0]   sum_wide;
  logic [DIST_W-1:0] sum_sat;
  logic              edge_hit;
  logic              relax_take;
  logic              scan_better;
  logic              scan_done;
  logic              out_set;

  // Effective node count: zero counts as one, large values clip to MAX_NODES.
  always_comb begin
    n_eff = CW'(node_count_r);
    if (n_eff == '0) begin
      n_eff = CW'(1);
    end else if (n_eff > CW'(MAX_NODES)) begin
      n_eff = CW'(MAX_NODES);
    end
  end

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  assign from_bad  = CW'(in_ch.from_node) >= n_eff;
  assign to_bad    = CW'(in_ch.to_node) >= n_eff;
  assign start_bad = CW'(in_ch.start_node) >= n_eff;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.node        = out_node_r;
  assign out_ch.distance    = out_dist_r;
  assign out_ch.predecessor = out_pred_r;
  assign out_ch.error       = out_err_r;
  assign out_ch.last        = out_last_r;

  // Relaxation arithmetic: saturating add of the finalized distance and weight.
  assign sum_wide = {1'b0, pend_r.dval} + (DIST_W + 1)'(edge_q.weight);
  assign sum_sat  = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
  assign edge_hit = (CW'(edge_q.from_n) == CW'(u_r)) && (CW'(edge_q.to_n) < n_eff);
  assign relax_take = !reached_r[tgt_r] || (sum_sat < node_q.dval);

  // A scanned node beats the current best only on a strictly smaller distance,
  // so ties keep the lower index.
  assign scan_better = scan_vld_r && reached_r[scan_idx_r] && !visited_r[scan_idx_r] &&
                       (!found_r || (node_q.dval < best_r.dval));

  // The scan is over once every node has been issued and the last compare is done.
  assign scan_done = (scan_i_r >= n_eff) && !scan_vld_r;

  // A new result word is loaded on an error command or at the end of a scan
  // that has a finalized node waiting to go out.
  always_comb begin
    out_set = 1'b0;
    if ((state_r == S_IDLE) && in_fire) begin
      if ((in_ch.op == OP_ADD) &&
          (from_bad || to_bad || (edge_total_r == ETW'(MAX_EDGES)))) begin
        out_set = 1'b1;
      end
      if ((in_ch.op == OP_RUN) && start_bad) begin
        out_set = 1'b1;
      end
    end
    if ((state_r == S_SCAN) && scan_done && have_pend_r) begin
      out_set = 1'b1;
    end
  end

  // Memory port control.
  always_comb begin
    edge_we = 1'b0;
    edge_wd.from_n = in_ch.from_node;
    edge_wd.to_n   = in_ch.to_node;
    edge_wd.weight = WEIGHT_BITS'(in_ch.edge_weight);
    node_we = 1'b0;
    node_wa = tgt_r;
    node_wd.dval = sum_sat;
    node_wd.pred = PW'(u_r);
    node_ra = scan_i_r[NIW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_ch.op == OP_ADD) && !from_bad && !to_bad &&
            (edge_total_r != ETW'(MAX_EDGES))) begin
          edge_we = 1'b1;
        end
        if (in_fire && (in_ch.op == OP_RUN) && !start_bad) begin
          node_we      = 1'b1;
          node_wa      = NIW'(in_ch.start_node);
          node_wd.dval = '0;
          node_wd.pred = PRED_NONE;
        end
      end
      S_EDGE_CHK: begin
        node_ra = NIW'(edge_q.to_n);
      end
      S_NODE_WR: begin
        node_we = relax_take;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_total_r[EAW-1:0]] <= edge_wd;
    end
    edge_q <= edge_mem[e_r[EAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    node_q <= node_mem[node_ra];
  end

  // Control sequencer and registered result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= CNT_W'(64);
      edge_total_r <= '0;
      e_r          <= '0;
      reached_r    <= '0;
      visited_r    <= '0;
      scan_i_r     <= '0;
      scan_vld_r   <= 1'b0;
      found_r      <= 1'b0;
      have_pend_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_data;
      end
      out_valid_r <= out_set || (out_valid_r && !out_ch.ready);
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            out_node_r <= '0;
            out_dist_r <= '0;
            out_pred_r <= PRED_W'(PRED_NONE);
            out_last_r <= 1'b1;
            case (in_ch.op)
              OP_CLEAR: begin
                edge_total_r <= '0;
              end
              OP_ADD: begin
                if (from_bad || to_bad) begin
                  out_err_r   <= ERR_NODE;
                end else if (edge_total_r == ETW'(MAX_EDGES)) begin
                  out_err_r   <= ERR_FULL;
                end else begin
                  edge_total_r <= edge_total_r + ETW'(1);
                end
              end
              OP_RUN: begin
                if (start_bad) begin
                  out_err_r   <= ERR_NODE;
                end else begin
                  reached_r   <= MAX_NODES'(1) << in_ch.start_node;
                  visited_r   <= '0;
                  have_pend_r <= 1'b0;
                  scan_i_r    <= '0;
                  scan_vld_r  <= 1'b0;
                  found_r     <= 1'b0;
                  state_r     <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          // One node read is issued per cycle; its data is compared in the next cycle.
          if (scan_i_r < n_eff) begin
            scan_vld_r <= 1'b1;
            scan_idx_r <= scan_i_r[NIW-1:0];
            scan_i_r   <= scan_i_r + CW'(1);
          end else begin
            scan_vld_r <= 1'b0;
          end
          if (scan_better) begin
            found_r  <= 1'b1;
            best_u_r <= scan_idx_r;
            best_r   <= node_q;
          end
          if (scan_done) begin
            if (have_pend_r) begin
              // The previous node goes out now that we know whether it is last.
              out_node_r  <= NODE_W'(u_r);
              out_dist_r  <= pend_r.dval;
              out_pred_r  <= PRED_W'(pend_r.pred);
              out_err_r   <= ERR_OK;
              out_last_r  <= !found_r;
              state_r     <= S_EMIT;
            end else begin
              visited_r[best_u_r] <= 1'b1;
              u_r         <= best_u_r;
              pend_r      <= best_r;
              have_pend_r <= 1'b1;
              e_r         <= '0;
              state_r     <= S_EDGE_RD;
            end
          end
        end
        S_EMIT: begin
          if (out_fire) begin
            if (found_r) begin
              visited_r[best_u_r] <= 1'b1;
              u_r     <= best_u_r;
              pend_r  <= best_r;
              e_r     <= '0;
              state_r <= S_EDGE_RD;
            end else begin
              have_pend_r <= 1'b0;
              state_r     <= S_IDLE;
            end
          end
        end
        S_EDGE_RD: begin
          // The edge read for e_r is issued by the memory block every cycle.
          if (e_r < edge_total_r) begin
            state_r <= S_EDGE_CHK;
          end else begin
            scan_i_r   <= '0;
            scan_vld_r <= 1'b0;
            found_r    <= 1'b0;
            state_r    <= S_SCAN;
          end
        end
        S_EDGE_CHK: begin
          if (edge_hit) begin
            tgt_r   <= NIW'(edge_q.to_n);
            state_r <= S_NODE_WR;
          end else begin
            e_r     <= e_r + ETW'(1);
            state_r <= S_EDGE_RD;
          end
        end
        S_NODE_WR: begin
          if (relax_take) begin
            reached_r[tgt_r] <= 1'b1;
          end
          e_r     <= e_r + ETW'(1);
          state_r <= S_EDGE_RD;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Every finalized node must have been reached first.
  a_visited_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (visited_r & ~reached_r) == '0)
    else $error("visited node that was never reached");

  // The edge count never passes the table size.
  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edge_total_r <= ETW'(MAX_EDGES))
    else $error("edge count beyond table size");

  // Error words always close their item.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_err_r != ERR_OK)) |-> out_last_r)
    else $error("error word without last");

  // A run in progress always has its source reached.
  a_run_source: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (reached_r != '0))
    else $error("scan with no reached node");

  // The sequencer never takes a word outside idle.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_IDLE) || (state_r == S_SCAN))
    else $error("unexpected state after accepting a word");

endmodule
`default_nettype wire
